/* design/uriscan_pkg.sv */
// Package for the HTTP origin-form URI scanner.
// Holds the phase, kind and status codes, the byte constants and the result type.
// No dependencies.
package uriscan_pkg;

    // Scanner phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PATH  = 2'd1,
        PH_QUERY = 2'd2
    } t_phase;

    // Classification of one byte
    typedef enum logic [1:0] {
        KIND_PATH  = 2'd0,
        KIND_QSEP  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_SPACE = 2'd3
    } t_kind;

    // Request status
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD     = 2'd1,
        ST_TOOLONG = 2'd2
    } t_status;

    localparam int unsigned LEN_W = 16;

    localparam logic [7:0]       CH_SLASH  = 8'h2F;
    localparam logic [7:0]       CH_HASH   = 8'h23;
    localparam logic [7:0]       CH_QMARK  = 8'h3F;
    localparam logic [7:0]       CH_SPACE  = 8'h20;
    localparam logic [7:0]       CH_NUL    = 8'h00;
    localparam logic [7:0]       CH_VIS_LO = 8'h21;
    localparam logic [7:0]       CH_VIS_HI = 8'h7E;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd8192;

    // One result item
    typedef struct packed {
        t_kind             kind;
        t_status           status;
        logic              done;
        logic [LEN_W-1:0]  len;
    } t_uri_res;

endpackage

/* design/uriscan_classify.sv */
// Per-byte classifier of the URI scanner: next phase, next length and result.
// Pure combinational logic. Depends on uriscan_pkg.
module uriscan_classify (
    input  uriscan_pkg::t_phase                  i_phase,
    input  logic [uriscan_pkg::LEN_W-1:0]        i_len,
    input  logic [uriscan_pkg::LEN_W-1:0]        i_max_len,
    input  logic [7:0]                           i_char,
    input  logic                                 i_first,
    output logic                                 o_emit,
    output uriscan_pkg::t_phase                  o_phase,
    output logic [uriscan_pkg::LEN_W-1:0]        o_len,
    output uriscan_pkg::t_uri_res                o_res
);

    uriscan_pkg::t_phase            ph;
    uriscan_pkg::t_kind             base_kind;
    logic [uriscan_pkg::LEN_W-1:0]  len_base;
    logic [uriscan_pkg::LEN_W-1:0]  len_inc;
    logic                           too_long;
    logic                           invisible;

    // A first byte restarts the URI with the count cleared
    assign ph        = i_first ? uriscan_pkg::PH_PATH : i_phase;
    assign len_base  = i_first ? '0 : i_len;
    assign len_inc   = len_base + uriscan_pkg::LEN_W'(1);
    assign too_long  = (len_inc >= i_max_len);
    assign invisible = (i_char < uriscan_pkg::CH_VIS_LO) || (i_char > uriscan_pkg::CH_VIS_HI);
    assign base_kind = (ph == uriscan_pkg::PH_PATH) ? uriscan_pkg::KIND_PATH
                                                    : uriscan_pkg::KIND_QUERY;

    // Byte classification
    always_comb begin
        o_emit       = 1'b1;
        o_len        = len_base;
        o_res.kind   = base_kind;
        o_res.status = uriscan_pkg::ST_OK;
        o_res.done   = 1'b0;
        if (i_first && (i_char != uriscan_pkg::CH_SLASH)) begin
            o_res.status = uriscan_pkg::ST_BAD;
            o_res.done   = 1'b1;
        end else if (!i_first && (i_phase != uriscan_pkg::PH_PATH)
                     && (i_phase != uriscan_pkg::PH_QUERY)) begin
            o_emit = 1'b0;
        end else if (i_char == uriscan_pkg::CH_SPACE) begin
            o_res.kind = uriscan_pkg::KIND_SPACE;
            o_res.done = 1'b1;
        end else if ((i_char == uriscan_pkg::CH_NUL) || (i_char == uriscan_pkg::CH_HASH)) begin
            o_res.status = uriscan_pkg::ST_BAD;
            o_res.done   = 1'b1;
        end else begin
            // counted byte
            o_len = len_inc;
            if ((ph == uriscan_pkg::PH_PATH) && (i_char == uriscan_pkg::CH_QMARK)) begin
                o_res.kind = uriscan_pkg::KIND_QSEP;
            end
            if (too_long) begin
                o_res.status = uriscan_pkg::ST_TOOLONG;
                o_res.done   = 1'b1;
            end else if (invisible) begin
                o_res.status = uriscan_pkg::ST_BAD;
                o_res.done   = 1'b1;
            end
        end
        o_res.len = o_len;
    end

    // Phase update: any finished URI drops back to idle; a '?' in the path enters the query
    always_comb begin
        if (!o_emit || o_res.done) begin
            o_phase = uriscan_pkg::PH_IDLE;
        end else if (o_res.kind == uriscan_pkg::KIND_QSEP) begin
            o_phase = uriscan_pkg::PH_QUERY;
        end else begin
            o_phase = ph;
        end
    end

endmodule

/* design/http_uri_origin_form_scanner.sv */
// Top level of the HTTP origin-form URI scanner: request/result registers and state.
// Depends on uriscan_pkg and uriscan_classify.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   tdata[7:0] char_in, tuser first
// m_axis    out  m_axis_tvalid/tready   tdata uri_length, tuser kind/status, tlast done
// cfg       in   i_cfg_wr_en            i_cfg_wr_data max_uri_length
//
// One byte accepted per cycle unless stalled; it moves via request then result register.
// Phase and length update in the same cycle the byte moves into the result register,
// so the following byte sees them at once.
// A stalled result register holds the byte in the request register; s_axis_tready
// stays high while the request register is empty or moving on.
// Synchronous active-low reset clears phase, length, valids; max length resets to 8192.
module http_uri_origin_form_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,   // max_uri_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] char_in
    input  logic        s_axis_tuser,    // [0] first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [15:0] uri_length
    output logic [3:0]  m_axis_tuser,    // [1:0] kind, [3:2] status
    output logic        m_axis_tlast     // done_res
);

    logic                           r_in_valid;
    logic [7:0]                     r_in_char;
    logic                           r_in_first;
    logic                           r_out_valid;
    uriscan_pkg::t_uri_res          r_out;
    uriscan_pkg::t_phase            r_phase;
    logic [uriscan_pkg::LEN_W-1:0]  r_len;
    logic [uriscan_pkg::LEN_W-1:0]  r_max_len;

    logic                           n_emit;
    uriscan_pkg::t_phase            n_phase;
    logic [uriscan_pkg::LEN_W-1:0]  n_len;
    uriscan_pkg::t_uri_res          n_res;
    logic                           out_free;
    logic                           adv;

    // Handshake control
    assign out_free      = !r_out_valid || m_axis_tready;
    assign adv           = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || adv;

    uriscan_classify u_classify (
        .i_phase   (r_phase),
        .i_len     (r_len),
        .i_max_len (r_max_len),
        .i_char    (r_in_char),
        .i_first   (r_in_first),
        .o_emit    (n_emit),
        .o_phase   (n_phase),
        .o_len     (n_len),
        .o_res     (n_res)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= uriscan_pkg::PH_IDLE;
            r_len       <= '0;
            r_max_len   <= uriscan_pkg::MAX_LEN_RESET;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= n_emit;
                r_phase     <= n_phase;
                r_len       <= n_len;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char  <= s_axis_tdata;
            r_in_first <= s_axis_tuser;
        end
        if (adv) begin
            r_out <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.len;
    assign m_axis_tuser  = {r_out.status, r_out.kind};
    assign m_axis_tlast  = r_out.done;

`ifndef SYNTHESIS
    // A finished URI always returns the scanner to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_emit && n_res.done) |=> (r_phase == uriscan_pkg::PH_IDLE))
        else $error("phase not idle after end of URI");

    // Any error status ends the URI
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out.status != uriscan_pkg::ST_OK)) |-> m_axis_tlast)
        else $error("error result without tlast");

    // Closing space is never an error
    a_space_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out.kind == uriscan_pkg::KIND_SPACE))
            |-> ((r_out.status == uriscan_pkg::ST_OK) && m_axis_tlast))
        else $error("closing space with bad status");

    // An empty result register never blocks a request
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> s_axis_tready)
        else $error("request stalled with free result register");
`endif

endmodule

/* tb/testbench.sv */
// Testbench for the HTTP origin-form URI scanner: a byte-level predictor in a small
// scoreboard class, random request and result idling, and several length limits.
// Depends on uriscan_pkg and http_uri_origin_form_scanner.
module testbench;
    import uriscan_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_PCT       = 21;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TIMEOUT_CYCLES = 200000;

    // Predicts the classification of every request byte and checks the results
    class uri_scoreboard;
        t_phase           phase;
        logic [LEN_W-1:0] count;
        logic [LEN_W-1:0] max_len;
        t_uri_res         due_results[$];
        int               produced;
        int               accepted;
        int               errors;

        function new();
            phase    = PH_IDLE;
            count    = '0;
            max_len  = MAX_LEN_RESET;
            produced = 0;
            accepted = 0;
            errors   = 0;
        endfunction

        // Builds one result from the running count; a finished URI sends us idle
        function t_uri_res settle(t_kind k, t_status s, logic d);
            t_uri_res r;
            r.kind   = k;
            r.status = s;
            r.done   = d;
            r.len    = count;
            if (d) begin
                phase = PH_IDLE;
            end
            return r;
        endfunction

        // Returns 1 when the byte gives a result, which is then in r
        function bit classify_byte(logic [7:0] c, logic f, output t_uri_res r);
            t_kind k;
            r = '0;
            if (f) begin
                // a first byte always restarts, whatever the phase
                count = '0;
                phase = PH_PATH;
                if (c != CH_SLASH) begin
                    r = settle(KIND_PATH, ST_BAD, 1'b1);
                    return 1'b1;
                end
            end else if (phase == PH_IDLE) begin
                return 1'b0;
            end
            k = (phase == PH_PATH) ? KIND_PATH : KIND_QUERY;
            if (c == CH_SPACE) begin
                r = settle(KIND_SPACE, ST_OK, 1'b1);
            end else if (c == CH_NUL || c == CH_HASH) begin
                r = settle(k, ST_BAD, 1'b1);
            end else begin
                // counted bytes: length limit first, then visibility
                count = count + 1'b1;
                if (phase == PH_PATH && c == CH_QMARK) begin
                    if (count >= max_len) begin
                        r = settle(KIND_QSEP, ST_TOOLONG, 1'b1);
                    end else begin
                        phase = PH_QUERY;
                        r = settle(KIND_QSEP, ST_OK, 1'b0);
                    end
                end else if (count >= max_len) begin
                    r = settle(k, ST_TOOLONG, 1'b1);
                end else if (c < CH_VIS_LO || c > CH_VIS_HI) begin
                    r = settle(k, ST_BAD, 1'b1);
                end else begin
                    r = settle(k, ST_OK, 1'b0);
                end
            end
            return 1'b1;
        endfunction

        function void note_request(logic [7:0] c, logic f);
            t_uri_res r;
            accepted++;
            if (classify_byte(c, f, r)) begin
                due_results.push_back(r);
                produced++;
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_result(t_kind k, t_status s, logic d, logic [LEN_W-1:0] len);
            t_uri_res e;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending (kind %0d len %0d)",
                                          k, len));
            end else begin
                e = due_results.pop_front();
                if (k !== e.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", k, e.kind));
                if (s !== e.status)
                    report_mismatch($sformatf("status %0d, expected %0d", s, e.status));
                if (d !== e.done)
                    report_mismatch($sformatf("done %0b, expected %0b", d, e.done));
                if (len !== e.len)
                    report_mismatch($sformatf("length %0d, expected %0d", len, e.len));
            end
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    uri_scoreboard sb;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_req   = 1'b0;
    int hold_left  = 0;

    http_uri_origin_form_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),     // [7:0] char_in
        .s_axis_tuser  (s_axis_tuser),     // [0] first
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),     // [15:0] uri_length
        .m_axis_tuser  (m_axis_tuser),     // [1:0] kind, [3:2] status
        .m_axis_tlast  (m_axis_tlast)      // done_res
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Offers one request byte, with random idle cycles ahead of it;
    // returns at the edge where the byte was taken, tvalid still high
    task automatic send_byte(input logic [7:0] c, input logic f);
        while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= f;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        sb.note_request(c, f);
    endtask

    // Stops offering and waits until every pending result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max(input logic [15:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.max_len = v;
    endtask

    function automatic logic [7:0] path_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(CH_VIS_LO, CH_VIS_HI));
        end while (c == CH_HASH || c == CH_QMARK);
        return c;
    endfunction

    function automatic logic [7:0] query_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(CH_VIS_LO, CH_VIS_HI));
        end while (c == CH_HASH);
        return c;
    endfunction

    // Bytes that end a URI early: NUL, hash, control or high bytes, early space
    function automatic logic [7:0] bad_char();
        case ($urandom_range(3))
            0: return CH_NUL;
            1: return CH_HASH;
            2: return 8'($urandom_range(8'h01, 8'h20));
            default: return 8'($urandom_range(8'h7F, 8'hFF));
        endcase
    endfunction

    // Well-formed URI with random content, sometimes broken or left open
    task automatic send_uri();
        int         plen;
        int         qlen;
        int         total;
        int         bad_at;
        bit         with_q;
        logic [7:0] c;
        plen   = int'($urandom_range(0, 14));
        with_q = 1'($urandom_range(1));
        qlen   = with_q ? int'($urandom_range(0, 10)) : 0;
        total  = plen + (with_q ? qlen + 1 : 0);
        bad_at = ($urandom_range(99) < 15) ? int'($urandom_range(1, total + 1)) : -1;
        send_byte(CH_SLASH, 1'b1);
        for (int i = 1; i <= total; i++) begin
            if (i == bad_at)
                c = bad_char();
            else if (i <= plen)
                c = path_char();
            else if (i == plen + 1)
                c = CH_QMARK;
            else
                c = query_char();
            send_byte(c, 1'b0);
        end
        if ($urandom_range(99) < 85) begin
            send_byte(CH_SPACE, 1'b0);
        end
    endtask

    // Sends about target request bytes, ignored ones included
    task automatic run_random(input int target);
        int start;
        start = sb.accepted;
        while (sb.accepted - start < target) begin
            if ($urandom_range(99) < 75)
                send_uri();
            else
                send_byte(8'($urandom_range(255)), $urandom_range(99) < 30);
        end
    endtask

    // Result side: check on each handshake, idle at random, long hold-off on demand
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                sb.check_result(t_kind'(m_axis_tuser[1:0]), t_status'(m_axis_tuser[3:2]),
                                m_axis_tlast, m_axis_tdata);
            end
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !rx_idle_en || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        sb.report_mismatch($sformatf("timeout with %0d results pending",
                                     sb.due_results.size()));
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Main sequence
    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset limit: path, separator, '?' inside query, closing space
        send_byte(CH_SLASH, 1'b1);
        send_byte("a", 1'b0);
        send_byte(CH_QMARK, 1'b0);
        send_byte(CH_QMARK, 1'b0);
        send_byte("=", 1'b0);
        send_byte(CH_SPACE, 1'b0);
        // visibility extremes, then hash in the path
        send_byte(CH_SLASH, 1'b1);
        send_byte(CH_VIS_HI, 1'b0);
        send_byte(CH_VIS_LO, 1'b0);
        send_byte(CH_HASH, 1'b0);
        // ignored while idle, then a first byte that is not a slash
        send_byte("x", 1'b0);
        send_byte(8'hFF, 1'b1);
        // NUL in the query
        send_byte(CH_SLASH, 1'b1);
        send_byte(CH_QMARK, 1'b0);
        send_byte(CH_NUL, 1'b0);
        // invisible byte in the path
        send_byte(CH_SLASH, 1'b1);
        send_byte(8'hFF, 1'b0);
        // restart in mid-path, then an invisible query byte
        send_byte(CH_SLASH, 1'b1);
        send_byte("b", 1'b0);
        send_byte(CH_SLASH, 1'b1);
        send_byte(CH_QMARK, 1'b0);
        send_byte(8'h80, 1'b0);
        drain();

        // every counted byte is too long
        write_max(16'd1);
        run_random(60);
        drain();
        write_max(16'd0);
        run_random(40);
        drain();

        // no length limit reached, and no idling on either side
        write_max(16'hFFFF);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random(150);
        drain();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        // short limit while the result side holds off for a long stretch
        write_max(16'd12);
        hold_req = 1'b1;
        run_random(150);
        drain();

        write_max(16'($urandom_range(2, 40)));
        run_random(150);
        drain();

        write_max(MAX_LEN_RESET);
        run_random(100);
        drain();

        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
